// ----- rtl/sip_pkg.sv -----
// Shared widths, outcome codes and stage payload types of the segment intersection pipeline.
package sip_pkg;

	// Coordinate width of every input and result field.
	localparam int CB = 32;
	// Difference of two coordinates.
	localparam int DW = CB + 1;
	// Product of two differences.
	localparam int PW = 2 * DW;
	// Difference of two products (cross product).
	localparam int CW = PW + 1;
	// Split of the numerator for the scaling multiply.
	localparam int LO = CW / 2;
	localparam int HI = CW - LO;
	// Scaled numerator and quotient widths.
	localparam int NW = CW + DW;
	localparam int QW = DW;
	// Stage numbering: four geometry stages, two scaling stages, one stage per
	// quotient bit, then the result register.
	localparam int FIRST_DIV = 7;
	localparam int NS = FIRST_DIV + QW;

	typedef enum logic [2:0] {
		OC_HIT      = 3'd0,
		OC_BOX      = 3'd1,
		OC_STRADDLE = 3'd2,
		OC_PARALLEL = 3'd3,
		OC_OUTSIDE  = 3'd4
	} outcome_t;

	typedef struct packed {
		logic signed [CB-1:0] a0x;
		logic signed [CB-1:0] a0y;
		logic signed [CB-1:0] a1x;
		logic signed [CB-1:0] a1y;
		logic signed [CB-1:0] b0x;
		logic signed [CB-1:0] b0y;
		logic signed [CB-1:0] b1x;
		logic signed [CB-1:0] b1y;
	} seg_t;

	typedef struct packed {
		outcome_t             code;
		logic signed [CB-1:0] a0x;
		logic signed [CB-1:0] a0y;
		logic                 neg_x;
		logic                 neg_y;
		logic [DW-1:0]        mag_x;
		logic [DW-1:0]        mag_y;
		logic [CW-1:0]        na;
		logic [CW-1:0]        den;
	} fr_t;

	typedef struct packed {
		outcome_t             code;
		logic signed [CB-1:0] a0x;
		logic signed [CB-1:0] a0y;
		logic                 neg_x;
		logic                 neg_y;
		logic [NW-1:0]        nx;
		logic [NW-1:0]        ny;
		logic [CW-1:0]        den;
	} sc_t;

	typedef struct packed {
		outcome_t             code;
		logic signed [CB-1:0] a0x;
		logic signed [CB-1:0] a0y;
		logic                 neg_x;
		logic                 neg_y;
		logic [NW-1:0]        rx;
		logic [NW-1:0]        ry;
		logic [NW-1:0]        dsh;
		logic [QW-1:0]        qx;
		logic [QW-1:0]        qy;
	} dv_t;

endpackage

// ----- rtl/sip_seg_if.sv -----
// Channel that carries one pair of segments.
interface sip_seg_if;
	logic                          valid;
	logic                          ready;
	logic signed [sip_pkg::CB-1:0] a_start_x;
	logic signed [sip_pkg::CB-1:0] a_start_y;
	logic signed [sip_pkg::CB-1:0] a_end_x;
	logic signed [sip_pkg::CB-1:0] a_end_y;
	logic signed [sip_pkg::CB-1:0] b_start_x;
	logic signed [sip_pkg::CB-1:0] b_start_y;
	logic signed [sip_pkg::CB-1:0] b_end_x;
	logic signed [sip_pkg::CB-1:0] b_end_y;

	modport source(output valid, a_start_x, a_start_y, a_end_x, a_end_y,
		b_start_x, b_start_y, b_end_x, b_end_y, input ready);
	modport sink(input valid, a_start_x, a_start_y, a_end_x, a_end_y,
		b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

// ----- rtl/sip_res_if.sv -----
// Channel that carries one intersection result.
interface sip_res_if;
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic [2:0]                    outcome;
	logic signed [sip_pkg::CB-1:0] cross_x;
	logic signed [sip_pkg::CB-1:0] cross_y;

	modport source(output valid, hit, outcome, cross_x, cross_y, input ready);
	modport sink(input valid, hit, outcome, cross_x, cross_y, output ready);
endinterface

// ----- rtl/sip_front.sv -----
// Geometry stages: box test, cross products, straddle and parameter tests.
module sip_front (
	input  logic                 clk,
	input  logic [3:0]           en,
	input  sip_pkg::seg_t        seg,
	output sip_pkg::fr_t         fr
);

	// Stage 1: differences and the box test.
	logic                              box_s1;
	logic signed [sip_pkg::CB-1:0]     a0x_s1, a0y_s1;
	logic signed [sip_pkg::DW-1:0]     dax_s1, day_s1, dbx_s1, dby_s1;
	logic signed [sip_pkg::DW-1:0]     abx_s1, aby_s1, ab1x_s1, ab1y_s1, ba1x_s1, ba1y_s1;

	logic apart_x, apart_y;
	always_comb begin
		apart_x = (seg.a0x < seg.b0x && seg.a0x < seg.b1x && seg.a1x < seg.b0x &&
			seg.a1x < seg.b1x) || (seg.b0x < seg.a0x && seg.b0x < seg.a1x &&
			seg.b1x < seg.a0x && seg.b1x < seg.a1x);
		apart_y = (seg.a0y < seg.b0y && seg.a0y < seg.b1y && seg.a1y < seg.b0y &&
			seg.a1y < seg.b1y) || (seg.b0y < seg.a0y && seg.b0y < seg.a1y &&
			seg.b1y < seg.a0y && seg.b1y < seg.a1y);
	end

	function automatic logic signed [sip_pkg::DW-1:0] diff(
		input logic signed [sip_pkg::CB-1:0] p, input logic signed [sip_pkg::CB-1:0] q);
		return {p[sip_pkg::CB-1], p} - {q[sip_pkg::CB-1], q};
	endfunction

	always_ff @(posedge clk) begin
		if (en[0]) begin
			box_s1  <= apart_x || apart_y;
			a0x_s1  <= seg.a0x;
			a0y_s1  <= seg.a0y;
			dax_s1  <= diff(seg.a1x, seg.a0x);
			day_s1  <= diff(seg.a1y, seg.a0y);
			dbx_s1  <= diff(seg.b1x, seg.b0x);
			dby_s1  <= diff(seg.b1y, seg.b0y);
			abx_s1  <= diff(seg.a0x, seg.b0x);
			aby_s1  <= diff(seg.a0y, seg.b0y);
			ab1x_s1 <= diff(seg.a0x, seg.b1x);
			ab1y_s1 <= diff(seg.a0y, seg.b1y);
			ba1x_s1 <= diff(seg.b0x, seg.a1x);
			ba1y_s1 <= diff(seg.b0y, seg.a1y);
		end
	end

	// Stage 2: the ten products.
	logic                              box_s2;
	logic signed [sip_pkg::CB-1:0]     a0x_s2, a0y_s2;
	logic signed [sip_pkg::DW-1:0]     dax_s2, day_s2;
	logic signed [sip_pkg::PW-1:0]     p1a_s2, p1b_s2, p2a_s2, p2b_s2, pna_s2, pnb_s2;
	logic signed [sip_pkg::PW-1:0]     p4a_s2, p4b_s2, pda_s2, pdb_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			box_s2 <= box_s1;
			a0x_s2 <= a0x_s1;
			a0y_s2 <= a0y_s1;
			dax_s2 <= dax_s1;
			day_s2 <= day_s1;
			p1a_s2 <= aby_s1 * dax_s1;
			p1b_s2 <= abx_s1 * day_s1;
			p2a_s2 <= day_s1 * ab1x_s1;
			p2b_s2 <= dax_s1 * ab1y_s1;
			pna_s2 <= dbx_s1 * aby_s1;
			pnb_s2 <= dby_s1 * abx_s1;
			p4a_s2 <= dby_s1 * ba1x_s1;
			p4b_s2 <= dbx_s1 * ba1y_s1;
			pda_s2 <= dax_s1 * dby_s1;
			pdb_s2 <= day_s1 * dbx_s1;
		end
	end

	// Stage 3: cross products. The cross product of B against A's start is the
	// negated numerator of A, and A's straddle cross against B's start is the
	// numerator of B.
	logic                              box_s3;
	logic signed [sip_pkg::CB-1:0]     a0x_s3, a0y_s3;
	logic signed [sip_pkg::DW-1:0]     dax_s3, day_s3;
	logic signed [sip_pkg::CW-1:0]     c1_s3, c2_s3, na_s3, c4_s3, den_s3;

	function automatic logic signed [sip_pkg::CW-1:0] xsub(
		input logic signed [sip_pkg::PW-1:0] p, input logic signed [sip_pkg::PW-1:0] q);
		return {p[sip_pkg::PW-1], p} - {q[sip_pkg::PW-1], q};
	endfunction

	always_ff @(posedge clk) begin
		if (en[2]) begin
			box_s3 <= box_s2;
			a0x_s3 <= a0x_s2;
			a0y_s3 <= a0y_s2;
			dax_s3 <= dax_s2;
			day_s3 <= day_s2;
			c1_s3  <= xsub(p1a_s2, p1b_s2);
			c2_s3  <= xsub(p2a_s2, p2b_s2);
			na_s3  <= xsub(pna_s2, pnb_s2);
			c4_s3  <= xsub(p4a_s2, p4b_s2);
			den_s3 <= xsub(pda_s2, pdb_s2);
		end
	end

	// Stage 4: classification and normalization to a positive denominator.
	function automatic logic is_pos(input logic signed [sip_pkg::CW-1:0] v);
		return !v[sip_pkg::CW-1] && (v != '0);
	endfunction

	logic                          straddle, outside, den_neg;
	logic signed [sip_pkg::CW-1:0] nae, nbe, dene;
	sip_pkg::outcome_t             code;

	always_comb begin
		den_neg  = den_s3[sip_pkg::CW-1];
		// The B-side cross against A's start is negative exactly when na is positive.
		straddle = (c1_s3[sip_pkg::CW-1] && is_pos(c2_s3)) ||
			(is_pos(c1_s3) && c2_s3[sip_pkg::CW-1]) ||
			(is_pos(na_s3) && is_pos(c4_s3)) ||
			(na_s3[sip_pkg::CW-1] && c4_s3[sip_pkg::CW-1]);
		nae  = den_neg ? -na_s3 : na_s3;
		nbe  = den_neg ? -c1_s3 : c1_s3;
		dene = den_neg ? -den_s3 : den_s3;
		outside = nae[sip_pkg::CW-1] || (nae > dene) || nbe[sip_pkg::CW-1] || (nbe > dene);
		if (box_s3) begin
			code = sip_pkg::OC_BOX;
		end else if (straddle) begin
			code = sip_pkg::OC_STRADDLE;
		end else if (den_s3 == '0) begin
			code = sip_pkg::OC_PARALLEL;
		end else if (outside) begin
			code = sip_pkg::OC_OUTSIDE;
		end else begin
			code = sip_pkg::OC_HIT;
		end
	end

	sip_pkg::fr_t fr_s4;
	always_ff @(posedge clk) begin
		if (en[3]) begin
			fr_s4.code  <= code;
			fr_s4.a0x   <= a0x_s3;
			fr_s4.a0y   <= a0y_s3;
			fr_s4.neg_x <= dax_s3[sip_pkg::DW-1];
			fr_s4.neg_y <= day_s3[sip_pkg::DW-1];
			fr_s4.mag_x <= dax_s3[sip_pkg::DW-1] ? -dax_s3 : dax_s3;
			fr_s4.mag_y <= day_s3[sip_pkg::DW-1] ? -day_s3 : day_s3;
			fr_s4.na    <= nae;
			fr_s4.den   <= dene;
		end
	end

	assign fr = fr_s4;

endmodule

// ----- rtl/sip_scale.sv -----
// Scaling stages: numerator times the magnitude of each axis delta, in two halves.
module sip_scale (
	input  logic          clk,
	input  logic [1:0]    en,
	input  sip_pkg::fr_t  fr,
	output sip_pkg::sc_t  sc
);

	logic [sip_pkg::LO+sip_pkg::DW-1:0] xl_s5, yl_s5;
	logic [sip_pkg::HI+sip_pkg::DW-1:0] xh_s5, yh_s5;
	sip_pkg::fr_t                       fr_s5;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			fr_s5 <= fr;
			xl_s5 <= fr.na[sip_pkg::LO-1:0] * fr.mag_x;
			xh_s5 <= fr.na[sip_pkg::CW-1:sip_pkg::LO] * fr.mag_x;
			yl_s5 <= fr.na[sip_pkg::LO-1:0] * fr.mag_y;
			yh_s5 <= fr.na[sip_pkg::CW-1:sip_pkg::LO] * fr.mag_y;
		end
	end

	sip_pkg::sc_t sc_s6;
	always_ff @(posedge clk) begin
		if (en[1]) begin
			sc_s6.code  <= fr_s5.code;
			sc_s6.a0x   <= fr_s5.a0x;
			sc_s6.a0y   <= fr_s5.a0y;
			sc_s6.neg_x <= fr_s5.neg_x;
			sc_s6.neg_y <= fr_s5.neg_y;
			sc_s6.den   <= fr_s5.den;
			sc_s6.nx    <= ({xh_s5, {sip_pkg::LO{1'b0}}}) + sip_pkg::NW'(xl_s5);
			sc_s6.ny    <= ({yh_s5, {sip_pkg::LO{1'b0}}}) + sip_pkg::NW'(yl_s5);
		end
	end

	assign sc = sc_s6;

endmodule

// ----- rtl/sip_div_stage.sv -----
// One restoring-division stage that settles one quotient bit on both axes.
module sip_div_stage (
	input  logic          clk,
	input  logic          en,
	input  sip_pkg::dv_t  d_in,
	output sip_pkg::dv_t  d_out
);

	logic ge_x, ge_y;
	assign ge_x = d_in.rx >= d_in.dsh;
	assign ge_y = d_in.ry >= d_in.dsh;

	sip_pkg::dv_t d_q;
	always_ff @(posedge clk) begin
		if (en) begin
			d_q.code  <= d_in.code;
			d_q.a0x   <= d_in.a0x;
			d_q.a0y   <= d_in.a0y;
			d_q.neg_x <= d_in.neg_x;
			d_q.neg_y <= d_in.neg_y;
			d_q.rx    <= ge_x ? d_in.rx - d_in.dsh : d_in.rx;
			d_q.ry    <= ge_y ? d_in.ry - d_in.dsh : d_in.ry;
			d_q.dsh   <= d_in.dsh >> 1;
			d_q.qx    <= {d_in.qx[sip_pkg::QW-2:0], ge_x};
			d_q.qy    <= {d_in.qy[sip_pkg::QW-2:0], ge_y};
		end
	end

	assign d_out = d_q;

endmodule

// ----- rtl/segment_intersection_point.sv -----
// Top level of the pipelined two-segment intersection unit.
//
//   channel | modport | moves
//   --------+---------+---------------------------------------------
//   seg     | sink    | two segments, eight signed coordinates
//   res     | source  | hit flag, outcome code, crossing point
//
// One pair enters per cycle while seg.ready is high and passes through
// four geometry stages, two scaling stages, one divider stage per quotient
// bit (33) and the result register. The depth is set by the bit-per-stage
// divider. Every stage has its own valid bit; a stage loads whenever it is
// empty or the stage after it moves, so a stall at the result port fills
// the bubbles first and only then holds seg.ready low. Reset clears only
// the valid bits.
module segment_intersection_point (
	input  logic       clk,
	input  logic       arst_n,
	sip_seg_if.sink    seg,
	sip_res_if.source  res
);

	localparam int NS = sip_pkg::NS;
	localparam int FD = sip_pkg::FIRST_DIV;

	// Stage occupancy and load enables, stage 1 at the input.
	logic [NS:1] v_q;
	logic [NS:1] en;

	always_comb begin
		en[NS] = !v_q[NS] || res.ready;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) v_q[1] <= seg.valid;
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	assign seg.ready = en[1];

	sip_pkg::seg_t seg_in;
	assign seg_in = '{a0x: seg.a_start_x, a0y: seg.a_start_y, a1x: seg.a_end_x,
		a1y: seg.a_end_y, b0x: seg.b_start_x, b0y: seg.b_start_y,
		b1x: seg.b_end_x, b1y: seg.b_end_y};

	sip_pkg::fr_t fr;
	sip_front u_front (.clk(clk), .en(en[4:1]), .seg(seg_in), .fr(fr));

	sip_pkg::sc_t sc;
	sip_scale u_scale (.clk(clk), .en(en[6:5]), .fr(fr), .sc(sc));

	// The divider starts with the denominator aligned to the top quotient bit.
	// The numerator is below den times two to the quotient width, since the
	// line parameter is at most one.
	sip_pkg::dv_t dv [0:sip_pkg::QW];
	assign dv[0] = '{code: sc.code, a0x: sc.a0x, a0y: sc.a0y, neg_x: sc.neg_x,
		neg_y: sc.neg_y, rx: sc.nx, ry: sc.ny,
		dsh: sip_pkg::NW'(sc.den) << (sip_pkg::QW - 1), qx: '0, qy: '0};

	for (genvar i = 0; i < sip_pkg::QW; i++) begin : g_div
		sip_div_stage u_div (.clk(clk), .en(en[FD+i]), .d_in(dv[i]), .d_out(dv[i+1]));
	end

	// Result stage: apply the delta sign, add the start point, zero on a miss.
	sip_pkg::dv_t                       dl;
	logic [sip_pkg::CB-1:0]             qx_t, qy_t;
	logic                               hit_c;
	assign dl    = dv[sip_pkg::QW];
	assign qx_t  = dl.qx[sip_pkg::CB-1:0];
	assign qy_t  = dl.qy[sip_pkg::CB-1:0];
	assign hit_c = dl.code == sip_pkg::OC_HIT;

	logic                          hit_s40;
	logic [2:0]                    outcome_s40;
	logic signed [sip_pkg::CB-1:0] cross_x_s40, cross_y_s40;

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			hit_s40     <= hit_c;
			outcome_s40 <= dl.code;
			cross_x_s40 <= hit_c ? dl.a0x + (dl.neg_x ? -qx_t : qx_t) : '0;
			cross_y_s40 <= hit_c ? dl.a0y + (dl.neg_y ? -qy_t : qy_t) : '0;
		end
	end

	assign res.valid   = v_q[NS];
	assign res.hit     = hit_s40;
	assign res.outcome = outcome_s40;
	assign res.cross_x = cross_x_s40;
	assign res.cross_y = cross_y_s40;

	// The hit flag and the outcome code must agree on every result.
	a_hit_code: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.hit == (res.outcome == sip_pkg::OC_HIT)))
		else $error("hit flag and outcome disagree");

	// A rejected pair reports the origin as its point.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.hit) |-> (res.cross_x == '0 && res.cross_y == '0))
		else $error("rejected result carries a point");

	// An empty result register never blocks the input.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!res.valid |-> seg.ready)
		else $error("input stalled with an empty result register");

	// A waiting result is not overwritten.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> (res.valid && $stable(res.outcome)))
		else $error("stalled result changed");

endmodule

// ----- tb/sip_checker.sv -----
`timescale 1ns / 1ps
// Checker that predicts each intersection result and compares it with the block's output.
module sip_checker (
	input  logic        clk,
	input  logic        arst_n,
	sip_seg_if          seg,
	sip_res_if          res,
	output int          fail_count,
	output int          pending,
	output int          hits_seen,
	output int          results_seen
);

	typedef struct {
		logic                          hit;
		sip_pkg::outcome_t             code;
		logic signed [sip_pkg::CB-1:0] px;
		logic signed [sip_pkg::CB-1:0] py;
	} crossing_t;

	crossing_t expected_q[$];

	// Exact cross product p*s - q*r on wide signed values.
	function automatic logic signed [191:0] cross_prod(longint p, longint q, longint r, longint s);
		logic signed [191:0] wp, wq, wr, ws;
		wp = p; wq = q; wr = r; ws = s;
		return wp * ws - wq * wr;
	endfunction

	function automatic logic straddle_fails(logic signed [191:0] a, logic signed [191:0] b);
		return (a < 0 && b > 0) || (a > 0 && b < 0);
	endfunction

	// Truncated num*delta/den with den > 0 and num in [0, den].
	function automatic longint scale_delta(logic signed [191:0] num, logic signed [191:0] den,
		longint delta);
		logic signed [191:0] mag, q;
		mag = (delta < 0) ? -delta : delta;
		q = (num * mag) / den;
		return (delta < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic crossing_t predict_crossing(sip_pkg::seg_t s);
		crossing_t r;
		longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
		logic signed [191:0] na, nb, den;
		ax0 = s.a0x; ay0 = s.a0y; ax1 = s.a1x; ay1 = s.a1y;
		bx0 = s.b0x; by0 = s.b0y; bx1 = s.b1x; by1 = s.b1y;
		r.hit = 1'b0; r.code = sip_pkg::OC_HIT; r.px = '0; r.py = '0;
		if ((ax0 > ax1 ? ax0 : ax1) < (bx0 < bx1 ? bx0 : bx1) ||
			(ay0 > ay1 ? ay0 : ay1) < (by0 < by1 ? by0 : by1) ||
			(bx0 > bx1 ? bx0 : bx1) < (ax0 < ax1 ? ax0 : ax1) ||
			(by0 > by1 ? by0 : by1) < (ay0 < ay1 ? ay0 : ay1)) begin
			r.code = sip_pkg::OC_BOX;
		end else if (straddle_fails(cross_prod(ax0-bx0, ay0-by0, ax0-ax1, ay0-ay1),
				cross_prod(ax0-ax1, ay0-ay1, ax0-bx1, ay0-by1)) ||
			straddle_fails(cross_prod(bx0-ax0, by0-ay0, bx0-bx1, by0-by1),
				cross_prod(bx0-bx1, by0-by1, bx0-ax1, by0-ay1))) begin
			r.code = sip_pkg::OC_STRADDLE;
		end else begin
			na  = cross_prod(bx1-bx0, by1-by0, ax0-bx0, ay0-by0);
			nb  = cross_prod(ax1-ax0, ay1-ay0, ax0-bx0, ay0-by0);
			den = cross_prod(ax1-ax0, ay1-ay0, bx1-bx0, by1-by0);
			if (den == 0) begin
				r.code = sip_pkg::OC_PARALLEL;
			end else begin
				if (den < 0) begin
					den = -den; na = -na; nb = -nb;
				end
				if (na < 0 || na > den || nb < 0 || nb > den) begin
					r.code = sip_pkg::OC_OUTSIDE;
				end else begin
					r.hit = 1'b1;
					r.px = sip_pkg::CB'(ax0 + scale_delta(na, den, ax1 - ax0));
					r.py = sip_pkg::CB'(ay0 + scale_delta(na, den, ay1 - ay0));
				end
			end
		end
		return r;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		crossing_t e;
		sip_pkg::seg_t s;
		if (!arst_n) begin
			fail_count <= 0;
			hits_seen <= 0;
			results_seen <= 0;
		end else begin
			if (seg.valid && seg.ready) begin
				s = '{seg.a_start_x, seg.a_start_y, seg.a_end_x, seg.a_end_y,
					seg.b_start_x, seg.b_start_y, seg.b_end_x, seg.b_end_y};
				expected_q.insert(expected_q.size(), predict_crossing(s));
			end
			if (res.valid && res.ready) begin
				results_seen <= results_seen + 1;
				if (res.hit) hits_seen <= hits_seen + 1;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result hit=%0b outcome=%0d x=%0d y=%0d", $time,
						res.hit, res.outcome, res.cross_x, res.cross_y);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_q.pop_front();
					if (res.hit !== e.hit || res.outcome !== e.code ||
						res.cross_x !== e.px || res.cross_y !== e.py) begin
						$display({"%0t: expected hit=%0b outcome=%0d x=%0d y=%0d, ",
							"got hit=%0b outcome=%0d x=%0d y=%0d"},
							$time, e.hit, e.code, e.px, e.py,
							res.hit, res.outcome, res.cross_x, res.cross_y);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ----- tb/segment_intersection_point_test.sv -----
`timescale 1ns / 1ps
// Top of the segment intersection testbench: clock, reset, stimulus and verdict.
module segment_intersection_point_test;

	localparam int RANDOM_PAIRS = 1600;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count, pending, hits_seen, results_seen;
	int idle_cycles = 0;
	int sent = 0;

	sip_seg_if seg();
	sip_res_if res();

	segment_intersection_point dut (.clk(clk), .arst_n(arst_n), .seg(seg), .res(res));
	sip_checker checker_i (.clk(clk), .arst_n(arst_n), .seg(seg), .res(res),
		.fail_count(fail_count), .pending(pending), .hits_seen(hits_seen),
		.results_seen(results_seen));

	always #4 clk = ~clk;

	// Gap length: mostly zero or short, now and then a long pause.
	function automatic int gap_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) return 0;
		if (pick < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// The result side stalls on its own, with quiet stretches mixed in.
	initial begin
		int stall;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			res.ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(negedge clk);
			stall = gap_length();
			if (stall > 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
		end
	end

	// Watchdog: nothing accepted on either side for too long ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((seg.valid && seg.ready) || (res.valid && res.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Present one segment pair at the falling edge and hold it until accepted.
	task automatic send_pair(sip_pkg::seg_t s);
		seg.valid     <= 1'b1;
		seg.a_start_x <= s.a0x; seg.a_start_y <= s.a0y;
		seg.a_end_x   <= s.a1x; seg.a_end_y   <= s.a1y;
		seg.b_start_x <= s.b0x; seg.b_start_y <= s.b0y;
		seg.b_end_x   <= s.b1x; seg.b_end_y   <= s.b1y;
		do @(posedge clk); while (!seg.ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic pause_sender();
		int gap;
		gap = gap_length();
		if (gap > 0) begin
			seg.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	function automatic logic signed [sip_pkg::CB-1:0] rand_coord(int scale);
		case (scale)
			0: return $signed(sip_pkg::CB'($urandom_range(0, 40))) - 20;
			1: return $signed(sip_pkg::CB'($urandom_range(0, 4000))) - 2000;
			2: return $signed(sip_pkg::CB'($urandom_range(0, 2000000))) - 1000000;
			default: return $signed($urandom());
		endcase
	endfunction

	// Random pair: mostly built around a shared point so the later tests are reached.
	function automatic sip_pkg::seg_t random_pair();
		sip_pkg::seg_t s;
		int scale;
		logic signed [sip_pkg::CB-1:0] cx, cy;
		scale = $urandom_range(0, 3);
		cx = rand_coord(scale);
		cy = rand_coord(scale);
		if ($urandom_range(0, 9) < 7 && scale < 3) begin
			s.a0x = cx - rand_coord(scale); s.a0y = cy - rand_coord(scale);
			s.a1x = 2 * cx - s.a0x + rand_coord(0);
			s.a1y = 2 * cy - s.a0y + rand_coord(0);
			s.b0x = cx + rand_coord(scale); s.b0y = cy + rand_coord(scale);
			if ($urandom_range(0, 7) == 0) begin
				// Parallel or collinear copy of segment A.
				s.b0x = s.a0x + rand_coord(0); s.b0y = s.a0y;
				s.b1x = s.a1x + (s.b0x - s.a0x); s.b1y = s.a1y;
			end else begin
				s.b1x = 2 * cx - s.b0x; s.b1y = 2 * cy - s.b0y;
			end
		end else begin
			s = '{rand_coord(scale), rand_coord(scale), rand_coord(scale), rand_coord(scale),
				rand_coord(scale), rand_coord(scale), rand_coord(scale), rand_coord(scale)};
		end
		return s;
	endfunction

	initial begin
		localparam logic signed [sip_pkg::CB-1:0] MAXC = {1'b0, {(sip_pkg::CB-1){1'b1}}};
		localparam logic signed [sip_pkg::CB-1:0] MINC = {1'b1, {(sip_pkg::CB-1){1'b0}}};
		sip_pkg::seg_t directed[$];
		int drain;
		seg.valid = 1'b0;
		{seg.a_start_x, seg.a_start_y, seg.a_end_x, seg.a_end_y} = '0;
		{seg.b_start_x, seg.b_start_y, seg.b_end_x, seg.b_end_y} = '0;

		// Plain cross, boxes apart twice, identical collinear, overlapping collinear, shared start point.
		directed.insert(directed.size(), '{-10, -10, 10, 10, -10, 10, 10, -10});
		directed.insert(directed.size(), '{0, 0, 5, 5, 10, 10, 20, 20});
		directed.insert(directed.size(), '{0, 0, 10, 0, 0, 5, 10, 1});
		directed.insert(directed.size(), '{0, 0, 10, 0, 0, 0, 10, 0});
		directed.insert(directed.size(), '{0, 0, 10, 10, 2, 2, 8, 8});
		directed.insert(directed.size(), '{0, 0, 10, 0, 0, 0, 0, 10});
		// Boxes touching at a corner where the endpoints meet, T junction.
		directed.insert(directed.size(), '{0, 0, 5, 5, 5, 5, 9, 0});
		directed.insert(directed.size(), '{0, 0, 10, 0, 5, 0, 5, 7});
		// Degenerate segments: a point on the other segment and two equal points.
		directed.insert(directed.size(), '{3, 3, 3, 3, 0, 0, 6, 6});
		directed.insert(directed.size(), '{4, 4, 4, 4, 4, 4, 4, 4});
		// Truncation toward zero on both signs.
		directed.insert(directed.size(), '{0, 0, 7, 3, 0, 3, 7, 0});
		directed.insert(directed.size(), '{0, 0, -7, -3, 0, -3, -7, 0});
		// Coordinate extremes.
		directed.insert(directed.size(), '{MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC});
		directed.insert(directed.size(), '{MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC});
		directed.insert(directed.size(), '{MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC, MAXC});
		directed.insert(directed.size(), '{MINC, 0, MAXC, 1, 0, MINC, 1, MAXC});
		directed.insert(directed.size(), '{-1, -1, -1, -1, -1, -1, -1, -1});
		directed.insert(directed.size(), '{MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC});
		directed.insert(directed.size(), '{MINC, MAXC, MAXC, MINC, -1, 0, 0, -1});

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			send_pair(directed[i]);
			if (i % 3 == 2) pause_sender();
		end
		repeat (RANDOM_PAIRS) begin
			send_pair(random_pair());
			if ($urandom_range(0, 2) == 0) pause_sender();
		end
		seg.valid <= 1'b0;

		drain = 0;
		while (pending != 0) @(negedge clk);
		while (drain < DRAIN_CYCLES) begin
			@(negedge clk);
			drain++;
		end

		$display("Sent %0d segment pairs (directed extremes and random), %0d results checked,",
			sent, results_seen);
		$display("%0d of them hits; %0d mismatches.", hits_seen, fail_count);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/sip_pkg.sv
rtl/sip_seg_if.sv
rtl/sip_res_if.sv
rtl/sip_front.sv
rtl/sip_scale.sv
rtl/sip_div_stage.sv
rtl/segment_intersection_point.sv
tb/sip_checker.sv
tb/segment_intersection_point_test.sv
